// ===== design/tpsq_pkg.sv =====
// Shared types and codes for the threshold prefix-sum query block.
`default_nettype none
package tpsq_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 42;
  localparam int STEPS_W = 11;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CMP,
    BK_SUM,
    BK_FIN
  } bk_state_t;

endpackage
`default_nettype wire

// ===== design/tpsq_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module tpsq_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/tpsq_queue.sv =====
// Two-entry request queue between the front and the back.
`default_nettype none
module tpsq_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tpsq_pkg::req_t push_req,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output tpsq_pkg::req_t     head
);
  import tpsq_pkg::*;

  req_t       entry_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = entry_r[rd_r];
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/tpsq_front.sv =====
// Input side: accept requests, decode the mode and drop unused codes.
`default_nettype none
module tpsq_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [tpsq_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                          q_full,
  output logic                               q_push,
  output tpsq_pkg::req_t                     q_req
);
  import tpsq_pkg::*;

  logic accept;
  logic keep;
  op_t  op;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    keep = 1'b1;
    op   = OP_CLEAR;
    unique case (in_mode)
      MODE_CLEAR: op = OP_CLEAR;
      MODE_LOAD:  op = OP_LOAD;
      MODE_QUERY: op = OP_QUERY;
      default:    keep = 1'b0;
    endcase
  end

  assign q_push       = accept & keep;
  assign q_req.op     = op;
  assign q_req.value  = in_value;
endmodule
`default_nettype wire

// ===== design/tpsq_back.sv =====
// Execution side: list update, binary search over prefix maxima, result register.
`default_nettype none
module tpsq_back #(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire tpsq_pkg::req_t               q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tpsq_pkg::TOTAL_W-1:0]      out_prefix_total,
  output logic [tpsq_pkg::STEPS_W-1:0]      out_steps_reached,
  output logic                              out_overflow
);
  import tpsq_pkg::*;

  localparam int EW = (ELEMENT_WIDTH < VALUE_W) ? ELEMENT_WIDTH : VALUE_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bk_state_t          state_r, state_nxt;
  logic [CW-1:0]      len_r, len_nxt;
  logic [TOTAL_W-1:0] rsum_r, rsum_nxt;
  logic [EW-1:0]      rmax_r, rmax_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      mid_r, mid_nxt;
  logic [VALUE_W-1:0] k_r, k_nxt;
  logic               ov_r, ov_nxt;
  logic [TOTAL_W-1:0] tot_r, tot_nxt;
  logic [STEPS_W-1:0] stp_r, stp_nxt;
  logic               ovo_r, ovo_nxt;

  logic [EW-1:0]      elem;
  logic [TOTAL_W-1:0] sum_add;
  logic [EW-1:0]      max_new;
  logic               we;
  logic               max_re;
  logic               sum_re;
  logic [AW-1:0]      max_raddr;
  logic [CW-1:0]      sum_idx;
  logic [EW-1:0]      max_rd;
  logic [TOTAL_W-1:0] sum_rd;
  logic               le;
  logic [CW-1:0]      clo, chi, cmid;

  assign elem    = q_head.value[EW-1:0];
  assign sum_add = rsum_r + TOTAL_W'(elem);
  assign max_new = (elem > rmax_r) ? elem : rmax_r;
  assign sum_idx = lo_r - CW'(1);

  assign le   = (VALUE_W'(max_rd) <= k_r);
  assign clo  = le ? (mid_r + CW'(1)) : lo_r;
  assign chi  = le ? hi_r : mid_r;
  assign cmid = clo + ((chi - clo) >> 1);

  tpsq_ram #(.W(EW), .D(DEPTH)) u_max_ram (
    .clk   (clk),
    .we    (we),
    .waddr (len_r[AW-1:0]),
    .wdata (max_new),
    .re    (max_re),
    .raddr (max_raddr),
    .rdata (max_rd)
  );

  tpsq_ram #(.W(TOTAL_W), .D(DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (we),
    .waddr (len_r[AW-1:0]),
    .wdata (sum_add),
    .re    (sum_re),
    .raddr (sum_idx[AW-1:0]),
    .rdata (sum_rd)
  );

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    rsum_nxt  = rsum_r;
    rmax_nxt  = rmax_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r & out_stall;
    tot_nxt   = tot_r;
    stp_nxt   = stp_r;
    ovo_nxt   = ovo_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    max_re    = 1'b0;
    sum_re    = 1'b0;
    max_raddr = mid_r[AW-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_CLEAR: begin
              len_nxt  = '0;
              rsum_nxt = '0;
              rmax_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            OP_LOAD: begin
              if (len_r >= CW'(DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                we       = 1'b1;
                rsum_nxt = sum_add;
                rmax_nxt = max_new;
                len_nxt  = len_r + CW'(1);
              end
            end
            OP_QUERY: begin
              k_nxt  = q_head.value;
              lo_nxt = '0;
              hi_nxt = len_r;
              if (len_r == '0) begin
                state_nxt = BK_SUM;
              end else begin
                mid_nxt   = len_r >> 1;
                max_raddr = mid_nxt[AW-1:0];
                max_re    = 1'b1;
                state_nxt = BK_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_CMP: begin
        lo_nxt = clo;
        hi_nxt = chi;
        if (clo < chi) begin
          mid_nxt   = cmid;
          max_raddr = cmid[AW-1:0];
          max_re    = 1'b1;
        end else begin
          state_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        sum_re    = 1'b1;
        state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          tot_nxt   = (lo_r == '0) ? '0 : sum_rd;
          stp_nxt   = STEPS_W'(lo_r);
          ovo_nxt   = ovf_r;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      len_r   <= '0;
      rsum_r  <= '0;
      rmax_r  <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rsum_r  <= rsum_nxt;
      rmax_r  <= rmax_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    k_r   <= k_nxt;
    tot_r <= tot_nxt;
    stp_r <= stp_nxt;
    ovo_r <= ovo_nxt;
  end

  assign out_valid         = ov_r;
  assign out_prefix_total  = tot_r;
  assign out_steps_reached = stp_r;
  assign out_overflow      = ovo_r;
endmodule
`default_nettype wire

// ===== design/threshold_prefix_sum_query.sv =====
// Top level of the threshold prefix-sum query block.
//
//   port group  direction  fields
//   in_         request    in_mode, in_value           (valid / stall)
//   out_        result     out_prefix_total, out_steps_reached, out_overflow
//
// Clear and load are each done on the pop in the back end; requests sustain one per cycle
// while no query holds the back end. A query holds the back end through the pop,
// one max-memory read per search step, then one sum-memory read and the result load.
// Reset is synchronous and empties the list and the queue; memories are not cleared.
// in_stall rises only when the two-entry queue is full; a stalled result holds the
// back end in its last step.
`default_nettype none
module threshold_prefix_sum_query #(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [tpsq_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tpsq_pkg::TOTAL_W-1:0]      out_prefix_total,
  output logic [tpsq_pkg::STEPS_W-1:0]      out_steps_reached,
  output logic                              out_overflow
);
  import tpsq_pkg::*;

  logic q_full;
  logic q_push;
  req_t q_req;
  logic q_pop;
  logic q_empty;
  req_t q_head;

  tpsq_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_req    (q_req)
  );

  tpsq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  tpsq_back #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prefix_total  (out_prefix_total),
    .out_steps_reached (out_steps_reached),
    .out_overflow      (out_overflow)
  );
endmodule
`default_nettype wire

// ===== design/tpsq_chk.sv =====
// Port-level checker for the threshold prefix-sum query block, with its bind.
`default_nettype none
module tpsq_chk #(
  parameter int DEPTH = 1024
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [41:0] out_prefix_total,
  input wire logic [10:0] out_steps_reached,
  input wire logic        out_overflow
);
  localparam bit NO_WRAP = (DEPTH < 2048);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prefix_total)
      && $stable(out_steps_reached) && $stable(out_overflow))
    else $error("stalled result changed");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("request stalled after reset");

  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    NO_WRAP && out_valid && out_steps_reached == 11'd0 |-> out_prefix_total == 42'd0)
    else $error("nonzero total for empty run");
endmodule

bind threshold_prefix_sum_query tpsq_chk #(.DEPTH(DEPTH)) u_tpsq_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_prefix_total  (out_prefix_total),
  .out_steps_reached (out_steps_reached),
  .out_overflow      (out_overflow)
);
`default_nettype wire
